### sv/tks_pkg.sv
// tks_pkg: types, constants and register codes of the top-k sorted selector
// no dependencies; imported by tks_cell and top_k_sorted_selector
`default_nettype none

package tks_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WIDE_W = (CNT_W > 6) ? CNT_W : 6;

  localparam int MODE_W = 2;
  localparam int LIM_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd2;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_END = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SORT_MODE = 2'd0,
    REG_RESULT_LIMIT = 2'd1,
    REG_SKIP_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic        func;
    logic [63:0] sort_key;
    logic [31:0] record_id;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_record_id;
    logic [63:0] out_key;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic   desc;
    logic   drain_en;
    entry_t ins;
  } cell_ctrl_t;

  typedef struct packed {
    logic seen_flag;
    logic seen_target;
  } chain_t;

  typedef struct packed {
    logic valid;
    logic at_count;
    logic is_tail;
  } cell_pos_t;

  typedef struct packed {
    logic target;
    logic tail_hit;
  } cell_stat_t;

endpackage

`default_nettype wire

### sv/top_k_sorted_selector.sv
// top_k_sorted_selector: chain of list cells, drain sequencer, stream path
// depends on tks_pkg and tks_cell
//
//   port group   dir   handshake                 payload
//   in           in    in_valid_i / in_ready_o   in_word_i (in_word_t)
//   out          out   out_valid_o / out_ready_i out_word_o (out_word_t)
//   cfg          in    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// for a record word all cells compare against the new key at once
// an end word in sorted mode drains the list if kept_count > skip count, one
// entry out of cell 0 per cycle while not stalled; no input word is taken meanwhile
// one output register; a stalled output holds the drain (skipped entries still shift) and the stream path
// reset clears counts and config; list contents need no reset
`default_nettype none

module top_k_sorted_selector
  import tks_pkg::*;
(
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  logic                  in_valid_i,
  output logic                        in_ready_o,
  input  wire  in_word_t              in_word_i,
  output logic                        out_valid_o,
  input  wire  logic                  out_ready_i,
  output out_word_t                   out_word_o,
  input  wire  logic                  cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MODE_W-1:0] sort_mode_q;
  logic [LIM_W-1:0]  result_limit_q;
  logic [LIM_W-1:0]  skip_count_q;

  logic [CNT_W-1:0]  kept_count_q, kept_count_d;
  logic [LIM_W-1:0]  skip_left_q, skip_left_d;
  logic [CNT_W-1:0]  emitted_q, emitted_d;
  logic              drain_q, drain_d;
  logic [CNT_W-1:0]  drain_idx_q, drain_idx_d;
  logic [CNT_W-1:0]  drain_n_q, drain_n_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic              in_fire;
  logic              is_sorted;
  logic              insert_en;
  logic              out_free;
  logic              append;
  logic              commit;
  logic              drain_skipping;
  logic              drain_shift;
  logic [WIDE_W-1:0] sum_w;
  logic [CNT_W-1:0]  kept_total;
  logic [CNT_W-1:0]  stream_limit;
  logic [CNT_W-1:0]  grown;
  logic [CNT_W-1:0]  base_n;
  cell_ctrl_t        ctrl;

  entry_t            ent [CAPACITY];
  chain_t            chain [CAPACITY+1];
  cell_stat_t        stat [CAPACITY];
  logic [CAPACITY-1:0] target_vec;
  logic [CAPACITY-1:0] commit_vec;
  logic [CAPACITY-1:0] tail_vec;
  logic [CAPACITY-1:0] flag_n_vec;

  assign is_sorted  = (sort_mode_q == MODE_ASC) || (sort_mode_q == MODE_DESC);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !drain_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign insert_en  = in_fire && (in_word_i.func == FUNC_RECORD) && is_sorted;

  assign sum_w = WIDE_W'(result_limit_q) + WIDE_W'(skip_count_q);
  assign kept_total = ((result_limit_q == '0) || (sum_w > WIDE_W'(CAPACITY))) ?
                      CNT_W'(CAPACITY) : sum_w[CNT_W-1:0];
  assign stream_limit = ((result_limit_q == '0) ||
                         (WIDE_W'(result_limit_q) > WIDE_W'(CAPACITY))) ?
                        CNT_W'(CAPACITY) : CNT_W'(result_limit_q);

  assign ctrl.desc     = (sort_mode_q == MODE_DESC);
  assign ctrl.ins.key  = in_word_i.sort_key;
  assign ctrl.ins.id   = in_word_i.record_id;
  assign drain_skipping = WIDE_W'(drain_idx_q) < WIDE_W'(skip_count_q);
  assign drain_shift   = drain_q && (drain_skipping || out_free);
  assign ctrl.drain_en = drain_shift;

  assign chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_pos_t pos;
    entry_t    prev_e;
    entry_t    next_e;
    logic      seen_flag_n;

    assign pos.valid    = CNT_W'(i) < kept_count_q;
    assign pos.at_count = CNT_W'(i) == kept_count_q;
    assign pos.is_tail  = (kept_count_q != '0) && (CNT_W'(i) == kept_count_q - 1'b1);

    if (i == 0) begin : g_head
      assign prev_e = ent[0];
    end else begin : g_body
      assign prev_e = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_e = ent[i];
    end else begin : g_mid
      assign next_e = ent[i+1];
    end

    tks_cell u_cell (
      .clk_i                      (clk_i),
      .ctrl_i                     (ctrl),
      .pos_i                      (pos),
      .append_i                   (append),
      .commit_i                   (commit),
      .chain_i                    (chain[i]),
      .prev_i                     (prev_e),
      .next_i                     (next_e),
      .chain_o_seen_flag_unused_n (seen_flag_n),
      .chain_o                    (chain[i+1]),
      .stat_o                     (stat[i]),
      .entry_o                    (ent[i])
    );

    assign flag_n_vec[i] = seen_flag_n;
    assign target_vec[i] = stat[i].target;
    assign tail_vec[i]   = stat[i].tail_hit;
    assign commit_vec[i] = stat[i].target && (CNT_W'(i) < kept_total);
  end

  assign append = (|tail_vec) || (kept_count_q == '0);
  assign commit = insert_en && (|commit_vec);

  assign grown  = (kept_count_q < CNT_W'(CAPACITY)) ? kept_count_q + 1'b1 : kept_count_q;
  assign base_n = commit ? grown : kept_count_q;

  always_comb begin
    kept_count_d = kept_count_q;
    skip_left_d  = skip_left_q;
    emitted_d    = emitted_q;
    drain_d      = drain_q;
    drain_idx_d  = drain_idx_q;
    drain_n_d    = drain_n_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_word_d   = out_word_q;

    if (insert_en) begin
      kept_count_d = (base_n > kept_total) ? kept_total : base_n;
    end

    if (in_fire && (in_word_i.func == FUNC_END)) begin
      kept_count_d = '0;
      skip_left_d  = skip_count_q;
      emitted_d    = '0;
      if (is_sorted && (WIDE_W'(skip_count_q) < WIDE_W'(kept_count_q))) begin
        drain_d     = 1'b1;
        drain_idx_d = '0;
        drain_n_d   = kept_count_q;
      end
    end

    if (in_fire && (in_word_i.func == FUNC_RECORD) && !is_sorted) begin
      if (skip_left_q != '0) begin
        skip_left_d = skip_left_q - 1'b1;
      end else if (emitted_q < stream_limit) begin
        emitted_d                = emitted_q + 1'b1;
        out_valid_d              = 1'b1;
        out_word_d.out_record_id = in_word_i.record_id;
        out_word_d.out_key       = in_word_i.sort_key;
        out_word_d.last          = (emitted_q + 1'b1) == stream_limit;
      end
    end

    if (drain_shift) begin
      drain_idx_d = drain_idx_q + 1'b1;
      if (!drain_skipping) begin
        out_valid_d              = 1'b1;
        out_word_d.out_record_id = ent[0].id;
        out_word_d.out_key       = ent[0].key;
        out_word_d.last          = drain_idx_q == drain_n_q - 1'b1;
        if (drain_idx_q == drain_n_q - 1'b1) begin
          drain_d = 1'b0;
        end
      end
    end

    if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_SKIP_COUNT)) begin
      skip_left_d = cfg_data_i[LIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_mode_q    <= MODE_NONE;
      result_limit_q <= '0;
      skip_count_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SORT_MODE:    sort_mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_RESULT_LIMIT: result_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_SKIP_COUNT:   skip_count_q   <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count_q <= '0;
      skip_left_q  <= '0;
      emitted_q    <= '0;
      drain_q      <= 1'b0;
      drain_idx_q  <= '0;
      drain_n_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      kept_count_q <= kept_count_d;
      skip_left_q  <= skip_left_d;
      emitted_q    <= emitted_d;
      drain_q      <= drain_d;
      drain_idx_q  <= drain_idx_d;
      drain_n_q    <= drain_n_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_count_q <= CNT_W'(CAPACITY))
    else $error("kept count above capacity");

  a_drain_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (drain_idx_q < drain_n_q))
    else $error("drain index past list length");

  a_one_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert_en |-> ($onehot0(target_vec) && ($countones(flag_n_vec) <= CAPACITY)))
    else $error("more than one insert slot");

endmodule

`default_nettype wire

### sv/tks_cell.sv
// tks_cell: one slot of the sorted list with its compare and shift logic
// depends on tks_pkg
`default_nettype none

module tks_cell
  import tks_pkg::*;
(
  input  wire  logic       clk_i,
  input  wire  cell_ctrl_t ctrl_i,
  input  wire  cell_pos_t  pos_i,
  input  wire  logic       append_i,
  input  wire  logic       commit_i,
  input  wire  chain_t     chain_i,
  input  wire  entry_t     prev_i,
  input  wire  entry_t     next_i,
  output logic             chain_o_seen_flag_unused_n,
  output chain_t           chain_o,
  output cell_stat_t       stat_o,
  output entry_t           entry_o
);

  entry_t entry_q;
  logic   kept_after;
  logic   key_after;
  logic   flag;
  logic   target;

  always_comb begin
    if (ctrl_i.desc) begin
      kept_after = $signed(entry_q.key) <= $signed(ctrl_i.ins.key);
      key_after  = $signed(ctrl_i.ins.key) <= $signed(entry_q.key);
    end else begin
      kept_after = $signed(entry_q.key) >= $signed(ctrl_i.ins.key);
      key_after  = $signed(ctrl_i.ins.key) >= $signed(entry_q.key);
    end
  end

  assign flag   = pos_i.valid & kept_after;
  assign target = append_i ? pos_i.at_count : (flag & ~chain_i.seen_flag);

  assign chain_o.seen_flag   = chain_i.seen_flag | flag;
  assign chain_o.seen_target = chain_i.seen_target | target;
  assign chain_o_seen_flag_unused_n = ~chain_o.seen_flag;

  assign stat_o.target   = target;
  assign stat_o.tail_hit = pos_i.is_tail & key_after;

  always_ff @(posedge clk_i) begin
    if (commit_i && target) begin
      entry_q <= ctrl_i.ins;
    end else if (commit_i && chain_i.seen_target) begin
      entry_q <= prev_i;
    end else if (ctrl_i.drain_en) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire
